[rtl/pps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package pps_pkg;

  // time needs room for the largest arrival plus every burst of a full set
  localparam int TIME_W   = 23;
  localparam int OUT_TW   = 21;
  localparam int IDX_W    = 6;   // covers the largest supported task count

  typedef logic [TIME_W-1:0] time_val_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  // running search record handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [7:0]       best_prio;
    logic [IDX_W-1:0] best_idx;
    logic [15:0]      best_rem;
    logic             nxt_valid;
    logic [15:0]      nxt_arr;
    logic             any_left;
  } carry_t;

  // one time slice granted to a task
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    time_val_t        run;
  } dispatch_t;

  // per-task figures moved out through the shift path
  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] burst;
    time_val_t   first;
    time_val_t   done;
  } res_t;

endpackage

[rtl/pps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_task_if / pps_result_if
// Valid/ready channels for task loading and result transfer.
// ----------------------------------------------------------------------------
interface pps_task_if;
  logic        valid;
  logic        ready;
  logic [15:0] arrival;
  logic [15:0] burst;
  logic [7:0]  prio;
  logic        last_task;

  modport source (output valid, arrival, burst, prio, last_task, input ready);
  modport sink   (input valid, arrival, burst, prio, last_task, output ready);
endinterface

interface pps_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  task_index;
  logic [20:0] completion;
  logic [20:0] turnaround;
  logic [20:0] waiting;
  logic [20:0] response;
  logic        last_result;

  modport source (output valid, task_index, completion, turnaround, waiting, response,
                  last_result, input ready);
  modport sink   (input valid, task_index, completion, turnaround, waiting, response,
                  last_result, output ready);
endinterface

[rtl/pps_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell
// One task slot: holds the task, joins the search record, takes dispatches, shifts results.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_en,
  input  logic [IW-1:0]        load_idx,
  input  logic [15:0]          load_arr,
  input  logic [15:0]          load_burst,
  input  logic [7:0]           load_prio,
  input  logic                 clear,
  input  pps_pkg::time_val_t   now,
  input  pps_pkg::dispatch_t   disp,
  input  logic                 shift_en,
  input  pps_pkg::res_t        shift_in,
  output pps_pkg::res_t        shift_out,
  input  pps_pkg::carry_t      carry_in,
  output pps_pkg::carry_t      carry_out
);
  import pps_pkg::*;

  logic        live;
  logic [15:0] arr;
  logic [15:0] burst;
  logic [15:0] rem;
  logic [7:0]  prio;
  logic        started;
  time_val_t   first;
  time_val_t   done;
  carry_t      carry_next;

  logic pending, is_ready, is_future, hit;

  assign pending   = live && (rem != 16'd0);
  assign is_ready  = pending && ({{(TIME_W-16){1'b0}}, arr} <= now);
  assign is_future = pending && !is_ready;
  assign hit       = disp.en && (disp.idx == IDX_W'(IDX));

  always_comb begin
    carry_next = carry_in;
    if (pending) carry_next.any_left = 1'b1;
    // strict compare keeps the lower index on a tie
    if (is_ready && (!carry_in.found || prio < carry_in.best_prio)) begin
      carry_next.found     = 1'b1;
      carry_next.best_prio = prio;
      carry_next.best_idx  = IDX_W'(IDX);
      carry_next.best_rem  = rem;
    end
    if (is_future && (!carry_in.nxt_valid || arr < carry_in.nxt_arr)) begin
      carry_next.nxt_valid = 1'b1;
      carry_next.nxt_arr   = arr;
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= 1'b0;
      started <= 1'b0;
    end else if (load_en && load_idx == IW'(IDX)) begin
      live  <= 1'b1;
      arr   <= load_arr;
      burst <= load_burst;
      rem   <= load_burst;
      prio  <= load_prio;
      // a zero burst finishes on arrival and never runs
      started <= (load_burst == 16'd0);
      first   <= {{(TIME_W-16){1'b0}}, load_arr};
      done    <= {{(TIME_W-16){1'b0}}, load_arr};
    end else if (clear) begin
      live    <= 1'b0;
      started <= 1'b0;
    end else if (shift_en) begin
      arr   <= shift_in.arr;
      burst <= shift_in.burst;
      first <= shift_in.first;
      done  <= shift_in.done;
    end else if (hit) begin
      if (!started) begin
        started <= 1'b1;
        first   <= now;
      end
      rem <= rem - disp.run[15:0];
      if ({{(TIME_W-16){1'b0}}, rem} == disp.run) done <= now + disp.run;
    end
  end

  assign shift_out = '{arr: arr, burst: burst, first: first, done: done};

endmodule

[rtl/preemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Loads a task set, simulates preemptive priority scheduling, reports per task.
// ----------------------------------------------------------------------------
// Tasks are taken one per cycle, one transfer each, into a row of MAX_TASKS
// cells. The set closes on last_task or when the row is full. Scheduling then
// runs event by event: each decision (a dispatch until the running task ends
// or the next arrival, or an idle skip to the next arrival) costs one sweep of
// the search record down the cell row. A set of n tasks needs at most about 2n
// decisions before the first result. Results then leave in load order, one per
// cycle while the sink takes them, by shifting the cell row towards cell 0. No
// new task is taken until all results of the set have left the row.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input logic    clk,
  input logic    rst,
  pps_task_if.sink     tasks,
  pps_result_if.source results
);
  import pps_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  state_t         state, state_next;
  logic [CW-1:0]  count;     // tasks loaded
  logic [CW-1:0]  emitted;   // results handed to the output register
  logic [CW-1:0]  sweep_cnt;
  time_val_t      now;

  carry_t         chain [MAX_TASKS+1];
  res_t           sh    [MAX_TASKS+1];
  dispatch_t      disp;

  logic take, close, sweep_done, emit_go, clear_row;
  carry_t    fin;
  time_val_t gap, run;

  assign tasks.ready = (state == ST_LOAD);
  assign take        = tasks.valid && tasks.ready;
  assign close       = take && (tasks.last_task || count == CW'(MAX_TASKS - 1));

  assign fin        = chain[MAX_TASKS];
  assign sweep_done = (state == ST_SWEEP) && (sweep_cnt == CW'(MAX_TASKS));
  assign gap        = {{(TIME_W-16){1'b0}}, fin.nxt_arr} - now;
  assign run = (fin.nxt_valid && gap < {{(TIME_W-16){1'b0}}, fin.best_rem}) ?
               gap : {{(TIME_W-16){1'b0}}, fin.best_rem};

  assign emit_go   = (state == ST_EMIT) && (emitted != count) &&
                     (!results.valid || results.ready);
  assign clear_row = (state == ST_EMIT) && (emitted == count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (close) state_next = ST_SWEEP;
      ST_SWEEP: if (sweep_done && !fin.any_left) state_next = ST_EMIT;
      ST_EMIT:  if (emitted == count) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs towards the cells
  always_comb begin
    disp.en  = sweep_done && fin.any_left && fin.found;
    disp.idx = fin.best_idx;
    disp.run = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      emitted   <= '0;
      sweep_cnt <= '0;
      now       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD && take) count <= count + 1'b1;
      if (clear_row) count <= '0;
      if (close) begin
        now       <= '0;
        sweep_cnt <= '0;
        emitted   <= '0;
      end else if (state == ST_SWEEP) begin
        if (sweep_done) begin
          sweep_cnt <= '0;
          if (fin.found)          now <= now + run;
          else if (fin.nxt_valid) now <= {{(TIME_W-16){1'b0}}, fin.nxt_arr};
        end else begin
          sweep_cnt <= sweep_cnt + 1'b1;
        end
      end
      if (emit_go) emitted <= emitted + 1'b1;
    end
  end

  assign chain[0]       = '0;
  assign sh[MAX_TASKS]  = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    pps_cell #(.IDX(k), .IW(IW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (take),
      .load_idx   (count[IW-1:0]),
      .load_arr   (tasks.arrival),
      .load_burst (tasks.burst),
      .load_prio  (tasks.prio),
      .clear      (clear_row),
      .now        (now),
      .disp       (disp),
      .shift_en   (emit_go),
      .shift_in   (sh[k+1]),
      .shift_out  (sh[k]),
      .carry_in   (chain[k]),
      .carry_out  (chain[k+1])
    );
  end

  // output register: metrics worked out from the head cell
  time_val_t turn_full;
  assign turn_full = sh[0].done - {{(TIME_W-16){1'b0}}, sh[0].arr};

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      results.task_index  <= 4'(emitted);
      results.completion  <= sh[0].done[OUT_TW-1:0];
      results.turnaround  <= turn_full[OUT_TW-1:0];
      results.waiting     <= OUT_TW'(turn_full - {{(TIME_W-16){1'b0}}, sh[0].burst});
      results.response    <= OUT_TW'(sh[0].first - {{(TIME_W-16){1'b0}}, sh[0].arr});
      results.last_result <= (emitted == count - 1'b1);
    end
  end

endmodule

[dv/pps_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_tb_pkg
// Task and result records used by the scheduler testbench.
// ----------------------------------------------------------------------------
package pps_tb_pkg;

  typedef struct {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic        last_task;
  } task_item_t;

  typedef struct {
    logic [3:0]  task_index;
    logic [20:0] completion;
    logic [20:0] turnaround;
    logic [20:0] waiting;
    logic [20:0] response;
    logic        last_result;
  } task_figs_t;

endpackage

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the preemptive priority scheduler against a behavioural schedule.
// ----------------------------------------------------------------------------
// Task sets are queued by an initial block and pushed by a clocked driver.
// Each accepted task is fed to a local scheduler copy; when a set closes the
// per-task figures are computed and queued. A clocked monitor compares each
// result transfer, field by field, with the oldest queued figure set.
// ----------------------------------------------------------------------------
module testbench;
  import pps_tb_pkg::*;

  localparam int NTASK = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pps_task_if   tasks ();
  pps_result_if results ();

  preemptive_priority_scheduler #(.MAX_TASKS(NTASK)) uut (
    .clk     (clk),
    .rst     (rst),
    .tasks   (tasks),
    .results (results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task_item_t pending_tasks[$];
  task_figs_t expected_figs[$];
  int         errors    = 0;
  int         n_results = 0;
  int         n_sets    = 0;
  bit         stim_done = 1'b0;
  bit         calm      = 1'b0;   // stretch with no idling on either side

  // scheduler copy: the currently open set
  logic [15:0] set_arr[NTASK];
  logic [15:0] set_burst[NTASK];
  logic [7:0]  set_prio[NTASK];
  int          set_count = 0;

  // Event-driven schedule of the closed set; figures queued in load order.
  task automatic schedule_set();
    longint t;
    longint nxt;
    longint run;
    longint rem[NTASK];
    longint first[NTASK];
    longint done[NTASK];
    bit     started[NTASK];
    int     left;
    int     best;
    task_figs_t f;
    left = 0;
    t = 0;
    for (int i = 0; i < set_count; i++) begin
      rem[i] = set_burst[i];
      started[i] = 1'b0;
      if (rem[i] == 0) begin
        // zero burst: finishes on arrival, never runs
        first[i] = set_arr[i];
        done[i] = set_arr[i];
      end else begin
        left++;
      end
    end
    while (left > 0) begin
      best = -1;
      nxt = -1;
      for (int i = 0; i < set_count; i++) begin
        if (rem[i] == 0) continue;
        if (set_arr[i] <= t) begin
          if (best < 0 || set_prio[i] < set_prio[best]) best = i;
        end else if (nxt < 0 || set_arr[i] < nxt) begin
          nxt = set_arr[i];
        end
      end
      if (best < 0) begin
        t = nxt;
        continue;
      end
      if (!started[best]) begin
        started[best] = 1'b1;
        first[best] = t;
      end
      run = rem[best];
      if (nxt >= 0 && nxt - t < run) run = nxt - t;
      rem[best] -= run;
      t += run;
      if (rem[best] == 0) begin
        done[best] = t;
        left--;
      end
    end
    for (int i = 0; i < set_count; i++) begin
      f.task_index  = i[3:0];
      f.completion  = done[i][20:0];
      f.turnaround  = 21'(done[i] - set_arr[i]);
      f.waiting     = 21'(done[i] - set_arr[i] - set_burst[i]);
      f.response    = 21'(first[i] - set_arr[i]);
      f.last_result = (i == set_count - 1);
      expected_figs.push_back(f);
    end
    set_count = 0;
    n_sets++;
  endtask

  // Driver: one task per transfer, occasional idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      tasks.valid     <= 1'b0;
      tasks.arrival   <= '0;
      tasks.burst     <= '0;
      tasks.prio      <= '0;
      tasks.last_task <= 1'b0;
    end else begin
      if (tasks.valid && tasks.ready) begin
        set_arr[set_count]   = tasks.arrival;
        set_burst[set_count] = tasks.burst;
        set_prio[set_count]  = tasks.prio;
        set_count++;
        // store full closes the set regardless of last_task
        if (tasks.last_task || set_count == NTASK) schedule_set();
      end
      if (!tasks.valid || tasks.ready) begin
        if (pending_tasks.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
          task_item_t it;
          it = pending_tasks.pop_front();
          tasks.valid     <= 1'b1;
          tasks.arrival   <= it.arrival;
          tasks.burst     <= it.burst;
          tasks.prio      <= it.prio;
          tasks.last_task <= it.last_task;
        end else begin
          tasks.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side stalls.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        n_results++;
        if (expected_figs.size() == 0) begin
          $display("%0t: unexpected result transfer, index %0d", $time,
                   results.task_index);
          errors++;
        end else begin
          task_figs_t e;
          e = expected_figs.pop_front();
          if (results.task_index !== e.task_index) begin
            $display("%0t: task_index exp %0d got %0d", $time, e.task_index,
                     results.task_index);
            errors++;
          end
          if (results.completion !== e.completion) begin
            $display("%0t: completion exp %0d got %0d", $time, e.completion,
                     results.completion);
            errors++;
          end
          if (results.turnaround !== e.turnaround) begin
            $display("%0t: turnaround exp %0d got %0d", $time, e.turnaround,
                     results.turnaround);
            errors++;
          end
          if (results.waiting !== e.waiting) begin
            $display("%0t: waiting exp %0d got %0d", $time, e.waiting, results.waiting);
            errors++;
          end
          if (results.response !== e.response) begin
            $display("%0t: response exp %0d got %0d", $time, e.response,
                     results.response);
            errors++;
          end
          if (results.last_result !== e.last_result) begin
            $display("%0t: last_result exp %0d got %0d", $time, e.last_result,
                     results.last_result);
            errors++;
          end
        end
      end
      results.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  function automatic task_item_t mk(int a, int b, int p, bit l);
    task_item_t it;
    it.arrival = a[15:0];
    it.burst = b[15:0];
    it.prio = p[7:0];
    it.last_task = l;
    return it;
  endfunction

  // Random set: mostly small times so tasks overlap and preempt.
  task automatic add_random_set(int n, bit wide);
    int a;
    int b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: a = $urandom_range(65535);
        1: a = 65535;
        default: a = wide ? $urandom_range(65535) : $urandom_range(40);
      endcase
      case ($urandom_range(9))
        0: b = 0;
        1: b = 65535;
        2: b = $urandom_range(65535);
        default: b = $urandom_range(1, 20);
      endcase
      pending_tasks.push_back(mk(a, b, $urandom_range(3) == 0 ? $urandom_range(255)
                                       : $urandom_range(3), i == n - 1));
    end
  endtask

  initial begin
    // directed: single task, ties, preemption, idle gap, zero burst, extremes
    pending_tasks.push_back(mk(0, 1, 0, 1));
    pending_tasks.push_back(mk(0, 4, 5, 0));
    pending_tasks.push_back(mk(0, 4, 5, 0));
    pending_tasks.push_back(mk(2, 3, 1, 0));
    pending_tasks.push_back(mk(20, 2, 255, 0));
    pending_tasks.push_back(mk(7, 0, 3, 1));
    pending_tasks.push_back(mk(65535, 65535, 255, 0));
    pending_tasks.push_back(mk(0, 65535, 0, 0));
    pending_tasks.push_back(mk(43690, 21845, 170, 1));
    // full store with last_task low everywhere closes on the sixteenth
    for (int i = 0; i < NTASK; i++)
      pending_tasks.push_back(mk(65535, 65535, 85 * (i % 4), 0));
    // random sets, mostly small
    while (pending_tasks.size() < 370)
      add_random_set($urandom_range(3) == 0 ? NTASK : $urandom_range(1, 6),
                     $urandom_range(4) == 0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (150) @(posedge clk);
    calm = 1'b1;
    repeat (2000) @(posedge clk);
    calm = 1'b0;
    while (pending_tasks.size() > 0 || tasks.valid) @(posedge clk);
    while (expected_figs.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d task sets scheduled, %0d per-task results checked", n_sets, n_results);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // full sets take one sweep of the cell row per decision; allow plenty
  initial begin
    #100ms;
    $display("testbench failed");
    $finish;
  end

endmodule
